// File: sv/s2c_pkg.sv
`default_nettype none

package s2c_pkg;

    // fixed-point widths
    localparam int ANGLE_W     = 16;
    localparam int TRIG_W      = 32;   // signed Q2.30
    localparam int ZACC_W      = 34;   // angle accumulator, 2^-32 turn units
    localparam int MUL_A_W     = 34;   // radius or unsaturated r*sin
    localparam int MUL_B_W     = 32;   // trig value
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RND_W       = PROD_W - 30;
    localparam int CAP_W       = 24;
    localparam int SLOT_OUT_W  = 24;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W  = 5;

    localparam logic [TRIG_W-1:0] CORDIC_GAIN   = 32'd652032874;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 24'd10000000;

    typedef struct packed {
        logic [31:0] radius;
        logic [15:0] polar_angle;
        logic [15:0] azimuth_angle;
        logic [31:0] lambda_bits;
    } point_in_t;

    typedef struct packed {
        logic signed [31:0] cart_x;
        logic signed [31:0] cart_y;
        logic signed [31:0] cart_z;
        logic [31:0]        tag_out;
        logic [23:0]        slot_index;
        logic               stored;
    } point_out_t;

    // sequencer to cordic
    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] angle;
    } cordic_req_t;

    // cordic to sequencer
    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } cordic_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THETA,
        ST_PHI,
        ST_MUL_RS,
        ST_MUL_RC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_FIN
    } state_t;

    // arctangent per step in 2^-32 turn units
    function automatic logic [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/s2c_cordic.sv
`default_nettype none

module s2c_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire s2c_pkg::cordic_req_t req,
    output s2c_pkg::cordic_res_t      res
);
    import s2c_pkg::*;

    localparam int STEPS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [ZACC_W-1:0] z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     flip_reg, flip_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [ANGLE_W-1:0]       folded;
    logic signed [TRIG_W-1:0] dx, dy;
    logic signed [ZACC_W-1:0] atan_z;
    logic                     last_step;

    // fold the angle into [-1/4, 1/4) turn, flip sign of results outside
    assign folded = {req.angle[ANGLE_W-1] ^ (req.angle[ANGLE_W-1] != req.angle[ANGLE_W-2]),
                     req.angle[ANGLE_W-2:0]};

    // one micro-rotation per cycle
    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_z    = $signed({{(ZACC_W-32){1'b0}}, atan_lut(ATAN_IDX_W'(step_reg))});
    assign last_step = (step_reg == STEP_W'(STEPS - 1));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = $signed(CORDIC_GAIN);
            y_next    = '0;
            z_next    = $signed({{(ZACC_W-ANGLE_W-16){folded[ANGLE_W-1]}}, folded, 16'h0000});
            step_next = '0;
            flip_next = (req.angle[ANGLE_W-1] != req.angle[ANGLE_W-2]);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZACC_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        flip_reg <= flip_next;
    end

    // results hold until the next start
    assign res.done    = done_reg;
    assign res.cos_val = flip_reg ? -x_reg : x_reg;
    assign res.sin_val = flip_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

// File: sv/s2c_mul.sv
`default_nettype none

module s2c_mul (
    input  wire                                clk,
    input  wire                                load,
    input  wire signed [s2c_pkg::MUL_A_W-1:0]  a,
    input  wire signed [s2c_pkg::MUL_B_W-1:0]  b,
    output logic signed [s2c_pkg::RND_W-1:0]   rnd
);
    import s2c_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] biased;

    // product register, loaded one operand pair at a time
    always_comb
    begin
        prod_next = load ? PROD_W'(a * b) : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // q30 to q0 with halves rounded up, floor shift
    assign biased = prod_reg + $signed(PROD_W'(64'h2000_0000));
    assign rnd    = biased[PROD_W-1:30];

endmodule

`default_nettype wire

// File: sv/spherical_to_cartesian_store.sv
`default_nettype none
// one point at a time: in_stall stays high from acceptance until the result is registered,
// since the single cordic unit is run twice (theta, phi) and the shared multiplier
//   does four products
// the input side takes a new point while a finished result waits on the output
// reset: asynchronous active low, slot counter cleared, capacity set to 10000000

module spherical_to_cartesian_store #(
    parameter int INDEX_WIDTH  = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire s2c_pkg::point_in_t   in_data,
    output logic                      out_valid,
    input  wire                       out_stall,
    output s2c_pkg::point_out_t       out_data,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [s2c_pkg::CAP_W-1:0]  cfg_data
);
    import s2c_pkg::*;

    localparam int CMP_W = (INDEX_WIDTH > CAP_W) ? INDEX_WIDTH : CAP_W;
    localparam logic [INDEX_WIDTH-1:0] SLOT_MAX = '1;

    state_t state_reg, state_next;

    logic [INDEX_WIDTH-1:0]   slot_reg, slot_next;
    logic [CAP_W-1:0]         cap_reg, cap_next;
    logic                     out_valid_reg, out_valid_next;
    point_out_t               out_data_reg, out_data_next;

    logic [31:0]              r_reg, r_next;
    logic [15:0]              az_reg, az_next;
    logic [31:0]              tag_reg, tag_next;
    logic signed [TRIG_W-1:0] ct_reg, ct_next;
    logic signed [TRIG_W-1:0] st_reg, st_next;
    logic signed [RND_W-1:0]  rs_reg, rs_next;
    logic signed [RND_W-1:0]  rc_reg, rc_next;
    logic signed [RND_W-1:0]  xx_reg, xx_next;

    cordic_req_t              cor_req;
    cordic_res_t              cor_res;
    logic                     mul_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [RND_W-1:0]  mul_rnd;
    logic                     out_free;

    function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
        logic signed [31:0] s;
        if (v[RND_W-1:31] == '0 || v[RND_W-1:31] == '1)
            s = v[31:0];
        else if (v[RND_W-1])
            s = 32'sh8000_0000;
        else
            s = 32'sh7FFF_FFFF;
        return s;
    endfunction

    s2c_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .res   (cor_res)
    );

    s2c_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .rnd  (mul_rnd)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        r_next         = r_reg;
        az_next        = az_reg;
        tag_next       = tag_reg;
        ct_next        = ct_reg;
        st_next        = st_reg;
        rs_next        = rs_reg;
        rc_next        = rc_reg;
        xx_next        = xx_reg;
        cor_req.start  = 1'b0;
        cor_req.angle  = in_data.polar_angle;
        mul_load       = 1'b0;
        mul_a          = $signed({2'b00, r_reg});
        mul_b          = st_reg;

        // capacity register write
        if (cfg_valid)
            cap_next = cfg_data;

        // output beat taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    r_next        = in_data.radius;
                    az_next       = in_data.azimuth_angle;
                    tag_next      = in_data.lambda_bits;
                    cor_req.start = 1'b1;
                    state_next    = ST_THETA;
                end
            end
            ST_THETA:
            begin
                cor_req.angle = az_reg;
                if (cor_res.done)
                begin
                    ct_next       = cor_res.cos_val;
                    st_next       = cor_res.sin_val;
                    cor_req.start = 1'b1;
                    state_next    = ST_PHI;
                end
            end
            ST_PHI:
            begin
                if (cor_res.done)
                    state_next = ST_MUL_RS;
            end
            ST_MUL_RS:
            begin
                mul_load   = 1'b1;
                state_next = ST_MUL_RC;
            end
            ST_MUL_RC:
            begin
                rs_next    = mul_rnd;
                mul_load   = 1'b1;
                mul_b      = ct_reg;
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                rc_next    = mul_rnd;
                mul_load   = 1'b1;
                mul_a      = MUL_A_W'(rs_reg);
                mul_b      = cor_res.cos_val;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                xx_next    = mul_rnd;
                mul_load   = 1'b1;
                mul_a      = MUL_A_W'(rs_reg);
                mul_b      = cor_res.sin_val;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cart_x     = sat32(xx_reg);
                    out_data_next.cart_y     = sat32(mul_rnd);
                    out_data_next.cart_z     = sat32(rc_reg);
                    out_data_next.tag_out    = tag_reg;
                    out_data_next.slot_index = SLOT_OUT_W'(slot_reg);
                    out_data_next.stored     = (CMP_W'(slot_reg) < CMP_W'(cap_reg));
                    if (slot_reg != SLOT_MAX)
                        slot_next = slot_reg + INDEX_WIDTH'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            cap_reg       <= CAPACITY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        r_reg        <= r_next;
        az_reg       <= az_next;
        tag_reg      <= tag_next;
        ct_reg       <= ct_next;
        st_reg       <= st_next;
        rs_reg       <= rs_next;
        rc_reg       <= rc_next;
        xx_reg       <= xx_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_THETA)
        else $error("accepted beat did not start the theta rotation");

    a_done_in_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        cor_res.done |-> (state_reg == ST_THETA || state_reg == ST_PHI))
        else $error("cordic finished outside a rotation state");

    a_slot_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> slot_reg >= $past(slot_reg))
        else $error("slot counter went backward");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished point not moved to the output register");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_FIN |=> slot_reg == $past(slot_reg))
        else $error("slot counter moved outside result delivery");

endmodule

`default_nettype wire

// File: tb/sv/spherical_to_cartesian_store_tb.sv
`timescale 1ns / 100ps

module spherical_to_cartesian_store_tb;

    import s2c_pkg::*;

    localparam int  STEPS        = 16;
    localparam int  SLOT_BITS    = 24;
    localparam int  TAIL_CYCLES  = 2 * STEPS + 16;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint HALF_LSB  = 64'sd536870912;

    // arctangent of 2^-i in 2^-32 turn units
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    point_in_t            in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    point_out_t           out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    // predictor state
    logic [SLOT_BITS-1:0] slot_count = '0;
    logic [CAP_W-1:0]     slot_capacity = CAPACITY_RST;

    point_in_t            point_feed[$];
    point_out_t           predicted_points[$];
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    spherical_to_cartesian_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // cos and sin of a turn fraction, signed Q2.30
    function automatic void turn_trig(input logic [15:0] ang, output longint c,
                                      output longint s);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        int     i;
        a = longint'($signed(ang));
        flip = 1'b0;
        // fold the outer half turn onto the right half plane
        if (a >= 16384 || a < -16384)
        begin
            flip = 1'b1;
            a = a - 32768;
            if (a < -32768)
                a = a + 65536;
        end
        z = a * 65536;
        x = GAIN_Q30;
        y = 0;
        for (i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint q30_round(input longint p);
        return (p + HALF_LSB) >>> 30;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // cartesian point and slot for one accepted input beat; advances the slot count
    function automatic point_out_t convert_point(input point_in_t p);
        point_out_t res;
        longint     r;
        longint     ct;
        longint     st;
        longint     cp;
        longint     sp;
        longint     rs;
        longint     rc;
        r = longint'({32'd0, p.radius});
        turn_trig(p.polar_angle, ct, st);
        turn_trig(p.azimuth_angle, cp, sp);
        rs = q30_round(r * st);
        rc = q30_round(r * ct);
        res.cart_x     = clamp32(q30_round(rs * cp));
        res.cart_y     = clamp32(q30_round(rs * sp));
        res.cart_z     = clamp32(rc);
        res.tag_out    = p.lambda_bits;
        res.slot_index = slot_count[23:0];
        res.stored     = (slot_count < slot_capacity);
        if (slot_count != '1)
            slot_count = slot_count + 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // input driver: hold payload while stalled, random gaps between beats
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                predicted_points.push_back(convert_point(in_data));
            if (point_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= point_feed.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        point_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_points.size() == 0)
                flag_mismatch("unexpected beat, tag", out_data.tag_out, 32'd0);
            else
            begin
                want = predicted_points.pop_front();
                if (out_data.cart_x !== want.cart_x)
                    flag_mismatch("cart_x", out_data.cart_x, want.cart_x);
                if (out_data.cart_y !== want.cart_y)
                    flag_mismatch("cart_y", out_data.cart_y, want.cart_y);
                if (out_data.cart_z !== want.cart_z)
                    flag_mismatch("cart_z", out_data.cart_z, want.cart_z);
                if (out_data.tag_out !== want.tag_out)
                    flag_mismatch("tag_out", out_data.tag_out, want.tag_out);
                if (out_data.slot_index !== want.slot_index)
                    flag_mismatch("slot_index", {8'd0, out_data.slot_index},
                                  {8'd0, want.slot_index});
                if (out_data.stored !== want.stored)
                    flag_mismatch("stored", {31'd0, out_data.stored}, {31'd0, want.stored});
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL spherical_to_cartesian_store");
            $finish;
        end
    end

    task automatic push_point(input logic [31:0] r, input logic [15:0] th,
                              input logic [15:0] ph, input logic [31:0] tag);
        point_in_t p;
        p.radius        = r;
        p.polar_angle   = th;
        p.azimuth_angle = ph;
        p.lambda_bits   = tag;
        point_feed.push_back(p);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] corners [10] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000,
                                     16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF, 16'h2000};
        if ($urandom_range(3) != 0)
            return 16'($urandom);
        return corners[$urandom_range(9)] + 16'($urandom_range(2)) - 16'd1;
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000);
            2: return 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF));
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // wait until no beat is queued, in flight or awaited
    task automatic wait_idle();
        @(negedge clk);
        while (point_feed.size() != 0 || in_valid || predicted_points.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slot_capacity = v;
        @(negedge clk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                             input logic [CAP_W-1:0] cap);
        wait_idle();
        write_capacity(cap);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n)
            push_point(pick_radius(), pick_angle(), pick_angle(), $urandom);
    endtask

    // stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed points at reset capacity: field extremes and quadrant edges
        send_idle_pct  = 16;
        recv_stall_pct = 79;
        push_point(32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0000);
        push_point(32'hFFFF_FFFF, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        push_point(32'hFFFF_FFFF, 16'h4000, 16'h0000, 32'h3F80_0000);
        push_point(32'hFFFF_FFFF, 16'h4000, 16'h4000, 32'h8000_0000);
        push_point(32'hFFFF_FFFF, 16'h4000, 16'h8000, 32'h7FFF_FFFF);
        push_point(32'hFFFF_FFFF, 16'hC000, 16'hC000, 32'h0000_0001);
        push_point(32'hFFFF_FFFF, 16'h8000, 16'h2000, 32'hDEAD_BEEF);
        push_point(32'h0001_0000, 16'h3FFF, 16'h3FFF, 32'h1234_5678);
        push_point(32'h0001_0000, 16'hBFFF, 16'hBFFF, 32'hA5A5_A5A5);
        push_point(32'h0001_0000, 16'h7FFF, 16'hFFFF, 32'h5A5A_5A5A);
        push_point(32'h0001_0000, 16'hFFFF, 16'h7FFF, 32'h0F0F_0F0F);
        push_point(32'h0001_0000, 16'h2000, 16'h6000, 32'hF0F0_F0F0);
        push_point(32'h7FFF_FFFF, 16'h2000, 16'h2000, 32'h0000_FFFF);
        push_point(32'h8000_0000, 16'h1000, 16'hE000, 32'hFFFF_0000);
        push_point(32'h0000_0001, 16'h4001, 16'hC001, 32'h0000_0000);
        push_point(32'h8000_0000, 16'h8000, 16'h0000, 32'h4049_0FDB);
        push_point(32'h0000_8000, 16'h0001, 16'h8001, 32'hFFFF_FFFF);
        push_point(32'hFFFF_FFFF, 16'h3000, 16'h9000, 32'h0000_0002);

        // capacity sweeps: none stored, a crossing, all stored, only the next one stored
        run_phase(380, 16, 79, '0);
        wait_idle();
        run_phase(380, 79, 16, slot_count + 24'd190);
        run_phase(200, 0, 0, '1);
        wait_idle();
        run_phase(190, 0, 0, slot_count + 24'd1);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_points.size() != 0)
            flag_mismatch("results never delivered", predicted_points.size(), 32'd0);
        if (fail_count == 0)
            $display("PASS spherical_to_cartesian_store");
        else
            $display("FAIL spherical_to_cartesian_store");
        $finish;
    end

endmodule
